[hw/rtl/irpdt_pkg.sv]
// ----------------------------------------------------------------------------
// irpdt_pkg
// Shared types and constants of the pulse-distance IR transmitter.
// ----------------------------------------------------------------------------
package irpdt_pkg;

  localparam int unsigned REG_COUNT   = 8;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned LEN_RESET_W = 16;
  localparam int unsigned FRAME_BITS  = 32;
  localparam int unsigned BIT_POS_W   = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HDR_MARK   = 3'd0,
    REG_HDR_SPACE  = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ZERO_SPACE = 3'd3,
    REG_ONE_SPACE  = 3'd4,
    REG_REP_SPACE  = 3'd5,
    REG_TAIL_MARK  = 3'd6,
    REG_TAIL_SPACE = 3'd7
  } reg_index_t;

  localparam logic [LEN_RESET_W-1:0] LEN_RESET [REG_COUNT] = '{
    16'd750, 16'd380, 16'd50, 16'd48, 16'd138, 16'd200, 16'd20, 16'd30
  };

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_HDR_MARK   = 9'b000000010,
    PH_HDR_SPACE  = 9'b000000100,
    PH_BIT_MARK   = 9'b000001000,
    PH_BIT_SPACE  = 9'b000010000,
    PH_REP_MARK   = 9'b000100000,
    PH_REP_SPACE  = 9'b001000000,
    PH_TAIL_MARK  = 9'b010000000,
    PH_TAIL_SPACE = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic carrier_enable;
    logic busy_res;
    logic frame_done;
  } result_t;

endpackage

[hw/rtl/irpdt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// irpdt_cfg_regs
// Segment length registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module irpdt_cfg_regs #(
  parameter int unsigned DURATION_WIDTH = 12
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  wr_en,
  input  logic [irpdt_pkg::CFG_INDEX_W-1:0]                     wr_index,
  input  logic [DURATION_WIDTH-1:0]                             wr_data,
  output logic [irpdt_pkg::REG_COUNT-1:0][DURATION_WIDTH-1:0]   durations
);
  import irpdt_pkg::*;

  logic [REG_COUNT-1:0][DURATION_WIDTH-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        len_r[i] <= LEN_RESET[i][DURATION_WIDTH-1:0];
      end
    end else if (wr_en) begin
      len_r[wr_index] <= wr_data;
    end
  end

  assign durations = len_r;

endmodule

[hw/rtl/irpdt_sequencer.sv]
// ----------------------------------------------------------------------------
// irpdt_sequencer
// Frame state: phase, segment timer, bit shifter and repeat counter.
// ----------------------------------------------------------------------------
module irpdt_sequencer #(
  parameter int unsigned DURATION_WIDTH = 12
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  xfer,
  input  logic                                                  op,
  input  logic [7:0]                                            address,
  input  logic [7:0]                                            command,
  input  logic [7:0]                                            repeat_count,
  input  logic [irpdt_pkg::REG_COUNT-1:0][DURATION_WIDTH-1:0]   durations,
  output irpdt_pkg::result_t                                    result
);
  import irpdt_pkg::*;

  localparam logic [DURATION_WIDTH-1:0] LEN_ONE = DURATION_WIDTH'(1);

  phase_t                      phase_r, phase_nxt;
  logic [DURATION_WIDTH-1:0]   tick_r, tick_nxt;
  logic [BIT_POS_W-1:0]        bit_pos_r, bit_pos_nxt;
  logic [FRAME_BITS-1:0]       shift_r, shift_nxt;
  logic [7:0]                  repeats_r, repeats_nxt;
  logic                        seg_end;

  function automatic logic [DURATION_WIDTH-1:0] seg_len(input logic [DURATION_WIDTH-1:0] v);
    return (v == '0) ? LEN_ONE : v;
  endfunction

  assign seg_end = (tick_r[DURATION_WIDTH-1:1] == '0);

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_pos_nxt = bit_pos_r;
    shift_nxt   = shift_r;
    repeats_nxt = repeats_r;
    result      = '0;
    if (xfer) begin
      if (op == OP_START) begin
        result.busy_res = 1'b1;
        if (phase_r == PH_IDLE) begin
          shift_nxt   = {address, ~address, command, ~command};
          repeats_nxt = repeat_count;
          bit_pos_nxt = '0;
          phase_nxt   = PH_HDR_MARK;
          tick_nxt    = seg_len(durations[REG_HDR_MARK]);
        end
      end else if (phase_r != PH_IDLE) begin
        result.busy_res       = 1'b1;
        result.carrier_enable = (phase_r == PH_HDR_MARK) || (phase_r == PH_BIT_MARK) ||
                                (phase_r == PH_REP_MARK) || (phase_r == PH_TAIL_MARK);
        if (tick_r != '0) begin
          tick_nxt = tick_r - LEN_ONE;
        end
        if (seg_end) begin
          unique case (phase_r)
            PH_HDR_MARK: begin
              phase_nxt = PH_HDR_SPACE;
              tick_nxt  = seg_len(durations[REG_HDR_SPACE]);
            end
            PH_HDR_SPACE: begin
              bit_pos_nxt = '0;
              phase_nxt   = PH_BIT_MARK;
              tick_nxt    = seg_len(durations[REG_BIT_MARK]);
            end
            PH_BIT_MARK: begin
              phase_nxt = PH_BIT_SPACE;
              tick_nxt  = shift_r[FRAME_BITS-1] ? seg_len(durations[REG_ONE_SPACE])
                                                : seg_len(durations[REG_ZERO_SPACE]);
            end
            PH_BIT_SPACE: begin
              shift_nxt   = {shift_r[FRAME_BITS-2:0], 1'b0};
              bit_pos_nxt = bit_pos_r + 1'b1;
              if (bit_pos_r == '1) begin
                if (repeats_r == '0) begin
                  phase_nxt = PH_TAIL_MARK;
                  tick_nxt  = seg_len(durations[REG_TAIL_MARK]);
                end else begin
                  phase_nxt = PH_REP_MARK;
                  tick_nxt  = seg_len(durations[REG_HDR_MARK]);
                end
              end else begin
                phase_nxt = PH_BIT_MARK;
                tick_nxt  = seg_len(durations[REG_BIT_MARK]);
              end
            end
            PH_REP_MARK: begin
              phase_nxt = PH_REP_SPACE;
              tick_nxt  = seg_len(durations[REG_REP_SPACE]);
            end
            PH_REP_SPACE: begin
              repeats_nxt = repeats_r - 8'd1;
              if (repeats_nxt == '0) begin
                phase_nxt         = PH_IDLE;
                tick_nxt          = '0;
                result.frame_done = 1'b1;
              end else begin
                phase_nxt = PH_REP_MARK;
                tick_nxt  = seg_len(durations[REG_HDR_MARK]);
              end
            end
            PH_TAIL_MARK: begin
              phase_nxt = PH_TAIL_SPACE;
              tick_nxt  = seg_len(durations[REG_TAIL_SPACE]);
            end
            default: begin
              phase_nxt         = PH_IDLE;
              tick_nxt          = '0;
              result.frame_done = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bit_pos_r <= '0;
      shift_r   <= '0;
      repeats_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_pos_r <= bit_pos_nxt;
      shift_r   <= shift_nxt;
      repeats_r <= repeats_nxt;
    end
  end

endmodule

[hw/rtl/ir_pulse_distance_transmitter.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter
// Tick-driven pulse-distance IR frame generator with a skid-buffered output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): a start item (in_op = 1) loads address,
//   command and repeat count; a tick item (in_op = 0) advances the waveform by
//   one time unit. A start while a frame runs is ignored.
//   Result channel (out_valid/out_stall): one result per input item, carrying
//   the carrier enable level, busy and the end-of-frame pulse for that tick.
//   Configuration channel (cfg_valid/cfg_ready): writes the eight segment
//   lengths; cfg_ready is always high. Write only while no result is pending.
//   The result is registered before out_valid rises; one item is taken every
//   cycle while in_stall is low.
//   When the receiver stalls, a second result is held in a skid register;
//   in_stall rises only once that register is full.
//   Reset clears the frame state and loads the default segment lengths.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter #(
  parameter int unsigned DURATION_WIDTH = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic [7:0]                            in_address,
  input  logic [7:0]                            in_command,
  input  logic [7:0]                            in_repeat_count,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_carrier_enable,
  output logic                                  out_busy_res,
  output logic                                  out_frame_done,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [irpdt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [DURATION_WIDTH-1:0]             cfg_data
);
  import irpdt_pkg::*;

  logic [REG_COUNT-1:0][DURATION_WIDTH-1:0] durations;
  result_t result;
  result_t out_r, out_nxt, skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic    in_xfer, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  irpdt_cfg_regs #(
    .DURATION_WIDTH(DURATION_WIDTH)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .durations(durations)
  );

  irpdt_sequencer #(
    .DURATION_WIDTH(DURATION_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .xfer        (in_xfer),
    .op          (in_op),
    .address     (in_address),
    .command     (in_command),
    .repeat_count(in_repeat_count),
    .durations   (durations),
    .result      (result)
  );

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = result;
        out_valid_nxt = in_xfer;
      end
    end else if (in_xfer) begin
      skid_nxt       = result;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_carrier_enable = out_r.carrier_enable;
  assign out_busy_res       = out_r.busy_res;
  assign out_frame_done     = out_r.frame_done;

endmodule

[hw/rtl/irpdt_checker.sv]
// ----------------------------------------------------------------------------
// irpdt_checker
// Port-level checks of the IR transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module irpdt_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_carrier_enable,
  input logic out_busy_res,
  input logic out_frame_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_carrier_enable) &&
                               $stable(out_busy_res) && $stable(out_frame_done))
    else $error("stalled result changed");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_busy_res)
    else $error("frame end without busy");

  a_carrier_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_carrier_enable |-> out_busy_res)
    else $error("carrier on while idle");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("handshake not cleared by reset");

endmodule

bind ir_pulse_distance_transmitter irpdt_checker u_irpdt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_carrier_enable(out_carrier_enable),
  .out_busy_res      (out_busy_res),
  .out_frame_done    (out_frame_done)
);

[tb/sv/ir_pulse_distance_transmitter_tb.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_tb
// Self-checking testbench for the tick-driven pulse-distance IR transmitter.
// A queue-fed driver offers start and tick transfers with random gaps, the
// receiver stalls at random and once holds off long enough to back up the
// input. A monitor predicts the carrier, busy and end-of-frame levels of every
// accepted transfer from its own copy of the segment lengths and frame state
// and compares each result transfer field by field against the oldest one.
// ----------------------------------------------------------------------------
module ir_pulse_distance_transmitter_tb;

  import irpdt_pkg::*;

  localparam int DUR_W       = 12;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic       op;
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] repeat_count;
  } tx_item_t;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic             in_op           = 1'b0;
  logic [7:0]       in_address      = 8'd0;
  logic [7:0]       in_command      = 8'd0;
  logic [7:0]       in_repeat_count = 8'd0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic             out_carrier_enable;
  logic             out_busy_res;
  logic             out_frame_done;
  logic             cfg_valid       = 1'b0;
  logic             cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0] cfg_data        = '0;

  // predicted transmitter state
  logic [DUR_W-1:0] len_reg [REG_COUNT];
  phase_t           tx_phase;
  logic [DUR_W-1:0] ticks_left;
  logic [5:0]       bit_idx;
  logic [31:0]      frame_bits;
  logic [7:0]       reps_left;

  tx_item_t         send_items [$];
  result_t          expected_levels [$];
  result_t          want_levels;
  tx_item_t         next_item;
  logic [DUR_W-1:0] next_len [REG_COUNT];

  logic             in_fire   = 1'b0;
  bit               in_quiet  = 1'b0;
  bit               out_quiet = 1'b0;
  int               in_gap    = 0;
  int               stall_left = 0;
  int               hold_left = 0;
  int               hold_requests = 0;
  int               holds_served = 0;
  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               random_items = 0;
  int               frames_sent = 0;
  int               seq_count = 0;
  int               kind;
  logic [7:0]       rep;

  ir_pulse_distance_transmitter #(
    .DURATION_WIDTH(DUR_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_address(in_address),
    .in_command(in_command),
    .in_repeat_count(in_repeat_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_carrier_enable(out_carrier_enable),
    .out_busy_res(out_busy_res),
    .out_frame_done(out_frame_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [DUR_W-1:0] seg_len(input reg_index_t r);
    return (len_reg[r] == '0) ? DUR_W'(1) : len_reg[r];
  endfunction

  function automatic void load_segment(input phase_t p, input reg_index_t r);
    tx_phase   = p;
    ticks_left = seg_len(r);
  endfunction

  function automatic result_t predict_levels(input tx_item_t it);
    result_t lv;
    lv = '0;
    if (it.op == OP_START) begin
      if (tx_phase == PH_IDLE) begin
        frame_bits = {it.address, ~it.address, it.command, ~it.command};
        reps_left  = it.repeat_count;
        bit_idx    = '0;
        load_segment(PH_HDR_MARK, REG_HDR_MARK);
      end
      lv.busy_res = 1'b1;
    end else if (tx_phase != PH_IDLE) begin
      lv.carrier_enable = tx_phase inside {PH_HDR_MARK, PH_BIT_MARK, PH_REP_MARK, PH_TAIL_MARK};
      lv.busy_res = 1'b1;
      if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
      if (ticks_left == '0) begin
        case (tx_phase)
          PH_HDR_MARK: load_segment(PH_HDR_SPACE, REG_HDR_SPACE);
          PH_HDR_SPACE: begin
            bit_idx = '0;
            load_segment(PH_BIT_MARK, REG_BIT_MARK);
          end
          PH_BIT_MARK: load_segment(PH_BIT_SPACE,
                                    frame_bits[31] ? REG_ONE_SPACE : REG_ZERO_SPACE);
          PH_BIT_SPACE: begin
            frame_bits = frame_bits << 1;
            bit_idx    = bit_idx + 1'b1;
            if (int'(bit_idx) < int'(FRAME_BITS)) load_segment(PH_BIT_MARK, REG_BIT_MARK);
            else if (reps_left == 8'd0) load_segment(PH_TAIL_MARK, REG_TAIL_MARK);
            else load_segment(PH_REP_MARK, REG_HDR_MARK);
          end
          PH_REP_MARK: load_segment(PH_REP_SPACE, REG_REP_SPACE);
          PH_REP_SPACE: begin
            reps_left = reps_left - 1'b1;
            if (reps_left != 8'd0) load_segment(PH_REP_MARK, REG_HDR_MARK);
            else lv.frame_done = 1'b1;
          end
          PH_TAIL_MARK: load_segment(PH_TAIL_SPACE, REG_TAIL_SPACE);
          default: lv.frame_done = 1'b1;
        endcase
        if (lv.frame_done) tx_phase = PH_IDLE;
      end
    end
    return lv;
  endfunction

  function automatic tx_item_t make_item(input logic op, input logic [7:0] a,
                                         input logic [7:0] c, input logic [7:0] r);
    tx_item_t it;
    it.op           = op;
    it.address      = a;
    it.command      = c;
    it.repeat_count = r;
    return it;
  endfunction

  function automatic tx_item_t tick_item();
    return make_item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic int pick_gap(input bit quiet);
    int roll;
    if (quiet) return 0;
    roll = int'($urandom_range(0, 99));
    if (roll < 55) return 0;
    if (roll < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 25));
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // queue one start and as many ticks as the frame lasts, plus extra (or minus), with stray starts mixed in
  task automatic push_frame(input logic [7:0] a, input logic [7:0] c,
                            input logic [7:0] r, input int extra);
    logic [31:0] bits;
    int          span;
    int          n;
    bits = {a, ~a, c, ~c};
    span = int'(seg_len(REG_HDR_MARK)) + int'(seg_len(REG_HDR_SPACE));
    for (int i = 0; i < int'(FRAME_BITS); i++) begin
      span += int'(seg_len(REG_BIT_MARK));
      span += int'(seg_len(bits[31-i] ? REG_ONE_SPACE : REG_ZERO_SPACE));
    end
    if (r == 8'd0) span += int'(seg_len(REG_TAIL_MARK)) + int'(seg_len(REG_TAIL_SPACE));
    else span += int'(r) * (int'(seg_len(REG_HDR_MARK)) + int'(seg_len(REG_REP_SPACE)));
    n = span + extra;
    if (n < 1) n = 1;
    send_items.push_back(make_item(OP_START, a, c, r));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0)
        send_items.push_back(make_item(OP_START, 8'($urandom), 8'($urandom), 8'($urandom)));
      send_items.push_back(tick_item());
    end
    random_items += n + 1;
    frames_sent++;
  endtask

  task automatic drain();
    while (send_items.size() != 0 || in_valid || expected_levels.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_len(input reg_index_t idx, input logic [DUR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_lengths();
    for (int i = 0; i < int'(REG_COUNT); i++) write_len(reg_index_t'(i), next_len[i]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // driver: hold a stalled transfer, otherwise insert a gap or offer the next item
  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (send_items.size() != 0) begin
        next_item = send_items.pop_front();
        in_op           <= next_item.op;
        in_address      <= next_item.address;
        in_command      <= next_item.command;
        in_repeat_count <= next_item.repeat_count;
        in_valid        <= 1'b1;
        in_gap = pick_gap(in_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap(out_quiet);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // monitor: track writes, check results, predict accepted items
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ir_pulse_distance_transmitter regression: fail");
      $finish;
    end else begin
      in_fire <= rst_n && in_valid && !in_stall;
      if (!rst_n) begin
        for (int i = 0; i < int'(REG_COUNT); i++) len_reg[i] = LEN_RESET[i][DUR_W-1:0];
        tx_phase   = PH_IDLE;
        ticks_left = '0;
        bit_idx    = '0;
        frame_bits = '0;
        reps_left  = '0;
      end else begin
        if (cfg_valid && cfg_ready) len_reg[cfg_index] = cfg_data;
        if (out_valid && !out_stall) begin
          if (expected_levels.size() == 0) begin
            report_mismatch("result transfer with no expectation pending");
          end else begin
            want_levels = expected_levels.pop_front();
            if (out_carrier_enable !== want_levels.carrier_enable)
              report_mismatch($sformatf("carrier_enable expected %b got %b",
                                        want_levels.carrier_enable, out_carrier_enable));
            if (out_busy_res !== want_levels.busy_res)
              report_mismatch($sformatf("busy_res expected %b got %b",
                                        want_levels.busy_res, out_busy_res));
            if (out_frame_done !== want_levels.frame_done)
              report_mismatch($sformatf("frame_done expected %b got %b",
                                        want_levels.frame_done, out_frame_done));
          end
        end
        if (in_valid && !in_stall)
          expected_levels.push_back(predict_levels(make_item(in_op, in_address,
                                                             in_command, in_repeat_count)));
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // default lengths: idle ticks, start, ignored start, end of the header mark
    send_items.push_back(tick_item());
    send_items.push_back(tick_item());
    send_items.push_back(make_item(OP_START, 8'h00, 8'hFF, 8'h00));
    send_items.push_back(make_item(OP_START, 8'hFF, 8'h00, 8'hFF));
    repeat (760) send_items.push_back(tick_item());
    drain();

    // shortest lengths, zero counting as one; finish the frame, idle ticks, then a new frame
    next_len[REG_HDR_MARK]   = DUR_W'(1);
    next_len[REG_HDR_SPACE]  = '0;
    next_len[REG_BIT_MARK]   = DUR_W'(1);
    next_len[REG_ZERO_SPACE] = '0;
    next_len[REG_ONE_SPACE]  = DUR_W'(1);
    next_len[REG_REP_SPACE]  = DUR_W'(1);
    next_len[REG_TAIL_MARK]  = '0;
    next_len[REG_TAIL_SPACE] = DUR_W'(1);
    program_lengths();
    repeat (450) send_items.push_back(tick_item());
    push_frame(8'hFF, 8'h00, 8'h02, 2);
    drain();

    random_items = 0;
    frames_sent  = 0;
    while (random_items < 200 || frames_sent < 2) begin
      if (seq_count % 5 == 0) begin
        drain();
        for (int i = 0; i < int'(REG_COUNT); i++) begin
          kind = int'($urandom_range(0, 9));
          if (kind == 0) next_len[i] = '0;
          else if (kind == 9) next_len[i] = DUR_W'($urandom_range(4, 10));
          else next_len[i] = DUR_W'($urandom_range(1, 3));
        end
        program_lengths();
      end
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      if (seq_count == 1) hold_requests++;
      kind = (seq_count == 1) ? 0 : int'($urandom_range(0, 9));
      rep  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 40)) : 8'($urandom_range(0, 3));
      if (kind < 7) begin
        push_frame(8'($urandom), 8'($urandom), rep, int'($urandom_range(0, 4)));
      end else if (kind == 7) begin
        push_frame(8'($urandom), 8'($urandom), rep, -int'($urandom_range(1, 200)));
      end else begin
        repeat ($urandom_range(1, 20))
          send_items.push_back(make_item(1'($urandom), 8'($urandom), 8'($urandom),
                                         8'($urandom)));
      end
      seq_count++;
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) $display("ir_pulse_distance_transmitter regression: pass");
    else $display("ir_pulse_distance_transmitter regression: fail");
    $finish;
  end

endmodule
